// ===== rtl/smdsa_pkg.sv =====
// smdsa_pkg: types, codes and constants of the data stack alu
// used by every module of the block, no dependencies
`timescale 1ns / 1ps

package smdsa_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int CELL_W = 32;
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int SP_W = $clog2(STACK_DEPTH + 1);

	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [SP_W-1:0] sp_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [4:0] {
		CMD_PUSH = 5'd0, CMD_DUP = 5'd1, CMD_DROP = 5'd2, CMD_SWAP = 5'd3,
		CMD_OVER = 5'd4, CMD_ROT = 5'd5, CMD_ADD = 5'd6, CMD_SUB = 5'd7,
		CMD_MUL = 5'd8, CMD_DIV = 5'd9, CMD_MOD = 5'd10, CMD_LAND = 5'd11,
		CMD_LOR = 5'd12, CMD_LNOT = 5'd13, CMD_BAND = 5'd14, CMD_BOR = 5'd15,
		CMD_BXOR = 5'd16, CMD_BNOT = 5'd17, CMD_EQ = 5'd18, CMD_NE = 5'd19,
		CMD_LT = 5'd20, CMD_LE = 5'd21, CMD_GT = 5'd22, CMD_GE = 5'd23,
		CMD_ARGC = 5'd24
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_DIVZ = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD_X2, S_RD_X3, S_RD_WAIT, S_EXEC, S_MUL, S_DIV, S_WR, S_RESP
	} state_t;

	typedef struct packed {
		logic [4:0] cmd;
		logic signed [31:0] literal;
	} in_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] top_value;
		logic [6:0] stack_depth;
	} out_rsp_t;

	typedef struct packed {
		logic we;
		addr_t waddr;
		cell_t wdata;
		logic re;
		addr_t raddr;
	} ram_req_t;

	function automatic logic [1:0] cmd_need(input logic [4:0] cmd);
		unique case (cmd)
			CMD_PUSH, CMD_ARGC: cmd_need = 2'd0;
			CMD_DUP, CMD_DROP, CMD_LNOT, CMD_BNOT: cmd_need = 2'd1;
			CMD_ROT: cmd_need = 2'd3;
			CMD_SWAP, CMD_OVER, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD,
			CMD_LAND, CMD_LOR, CMD_BAND, CMD_BOR, CMD_BXOR, CMD_EQ, CMD_NE,
			CMD_LT, CMD_LE, CMD_GT, CMD_GE: cmd_need = 2'd2;
			default: cmd_need = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] cmd_give(input logic [4:0] cmd);
		unique case (cmd)
			CMD_DROP: cmd_give = 2'd0;
			CMD_DUP, CMD_SWAP: cmd_give = 2'd2;
			CMD_OVER, CMD_ROT: cmd_give = 2'd3;
			CMD_PUSH, CMD_ARGC, CMD_LNOT, CMD_BNOT, CMD_ADD, CMD_SUB, CMD_MUL,
			CMD_DIV, CMD_MOD, CMD_LAND, CMD_LOR, CMD_BAND, CMD_BOR, CMD_BXOR,
			CMD_EQ, CMD_NE, CMD_LT, CMD_LE, CMD_GT, CMD_GE: cmd_give = 2'd1;
			default: cmd_give = 2'd0;
		endcase
	endfunction

endpackage

// ===== rtl/smdsa_ram.sv =====
// smdsa_ram: stack cell memory, one write and one registered read port
// depends on smdsa_pkg
`timescale 1ns / 1ps

module smdsa_ram (
	input logic clk,
	input smdsa_pkg::ram_req_t req,
	output smdsa_pkg::cell_t rdata
);
	import smdsa_pkg::*;

	cell_t mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== rtl/smdsa_div.sv =====
// smdsa_div: iterative signed divider, one quotient bit per cycle
// depends on smdsa_pkg
`timescale 1ns / 1ps

module smdsa_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input smdsa_pkg::cell_t dividend,
	input smdsa_pkg::cell_t divisor,
	output logic done,
	output smdsa_pkg::cell_t quo,
	output smdsa_pkg::cell_t rem
);
	import smdsa_pkg::*;

	localparam int CNT_W = $clog2(CELL_W);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CELL_W:0] rem_q;
	cell_t quo_q;
	cell_t b_q;
	logic qneg_q;
	logic rneg_q;
	logic [CELL_W:0] trial;
	logic fits;

	assign trial = {rem_q[CELL_W-1:0], quo_q[CELL_W-1]};
	assign fits = trial >= {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CELL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[CELL_W-1] ? cell_t'(-dividend) : dividend;
			b_q <= divisor[CELL_W-1] ? cell_t'(-divisor) : divisor;
			qneg_q <= dividend[CELL_W-1] ^ divisor[CELL_W-1];
			rneg_q <= dividend[CELL_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, b_q}) : trial;
			quo_q <= {quo_q[CELL_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo = qneg_q ? cell_t'(-quo_q) : quo_q;
	assign rem = rneg_q ? cell_t'(-rem_q[CELL_W-1:0]) : rem_q[CELL_W-1:0];

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q)) else $error("divider done without run");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q) else $error("divider busy after done");
	a_fits_rem: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rem_q < {1'b0, b_q} || b_q == '0) else $error("remainder too large");
`endif

endmodule

// ===== rtl/stack_machine_data_stack_alu.sv =====
// stack_machine_data_stack_alu: sequencer for one word per request
// a word reads its second and third operand from ram where it needs them, runs exec, then a mul
// step or the iterative divider, then writes each result cell in turn and responds; a rejected
// word goes straight to the response; one request in flight, none taken before the response
// reset clears stack pointer, cached top cell and argument count; cells stay unwritten
// depends on smdsa_pkg, smdsa_ram, smdsa_div
`timescale 1ns / 1ps

module stack_machine_data_stack_alu (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input smdsa_pkg::in_req_t in_req,
	output logic out_valid,
	input logic out_stall,
	output smdsa_pkg::out_rsp_t out_rsp
);
	import smdsa_pkg::*;

	state_t state_q, state_d;
	logic [7:0] argc_q;
	sp_t sp_q;
	cell_t top_q;
	logic [4:0] cmd_q;
	cell_t lit_q;
	status_t status_q;
	sp_t base_q;
	logic [1:0] give_q;
	logic [1:0] wr_idx_q;
	logic rd2_q, rd3_q, run_q;
	cell_t x2_q, x3_q;
	cell_t w_q [3];
	cell_t drop_top_q;
	logic [CELL_W-1:0] prod_q;
	logic out_valid_q;
	out_rsp_t out_q;

	logic accept;
	logic [1:0] need;
	logic [1:0] give;
	logic under, over, divz, nop;
	logic [SP_W:0] depth_after;
	logic [2*CELL_W-1:0] prod_full;
	cell_t alu;
	logic lt_ab, lt_ba;
	ram_req_t ram_req;
	cell_t rdata;
	logic div_start, div_done;
	cell_t div_quo, div_rem;

	smdsa_ram u_ram (.clk(clk), .req(ram_req), .rdata(rdata));

	smdsa_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(x2_q),
		.divisor(top_q), .done(div_done), .quo(div_quo), .rem(div_rem)
	);

	assign in_stall = state_q != S_IDLE;
	assign accept = in_valid && !in_stall;
	assign need = cmd_need(in_req.cmd);
	assign give = cmd_give(in_req.cmd);
	assign nop = in_req.cmd > 5'(CMD_ARGC);
	assign under = sp_q < SP_W'(need);
	assign depth_after = {1'b0, sp_q} - (SP_W + 1)'(need) + (SP_W + 1)'(give);
	assign over = depth_after > (SP_W + 1)'(STACK_DEPTH);
	assign divz = (in_req.cmd == CMD_DIV || in_req.cmd == CMD_MOD) && top_q == '0;

	assign prod_full = x2_q * top_q;
	assign lt_ab = $signed(x2_q) < $signed(top_q);
	assign lt_ba = $signed(top_q) < $signed(x2_q);

	always_comb begin
		unique case (cmd_q)
			CMD_ADD: alu = x2_q + top_q;
			CMD_SUB: alu = x2_q - top_q;
			CMD_LAND: alu = cell_t'(x2_q != '0 && top_q != '0);
			CMD_LOR: alu = cell_t'(x2_q != '0 || top_q != '0);
			CMD_BAND: alu = x2_q & top_q;
			CMD_BOR: alu = x2_q | top_q;
			CMD_BXOR: alu = x2_q ^ top_q;
			CMD_EQ: alu = cell_t'(x2_q == top_q);
			CMD_NE: alu = cell_t'(x2_q != top_q);
			CMD_LT: alu = cell_t'(lt_ab);
			CMD_LE: alu = cell_t'(!lt_ba);
			CMD_GT: alu = cell_t'(lt_ba);
			CMD_GE: alu = cell_t'(!lt_ab);
			CMD_LNOT: alu = cell_t'(top_q == '0);
			CMD_BNOT: alu = ~top_q;
			CMD_ARGC: alu = cell_t'(argc_q);
			default: alu = lit_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (under || over || divz || nop) state_d = S_RESP;
					else if (need >= 2'd2 || (in_req.cmd == CMD_DROP && sp_q >= SP_W'(2)))
						state_d = S_RD_X2;
					else state_d = S_EXEC;
				end
			end
			S_RD_X2: state_d = rd3_q ? S_RD_X3 : S_RD_WAIT;
			S_RD_X3: state_d = S_RD_WAIT;
			S_RD_WAIT: state_d = S_EXEC;
			S_EXEC: begin
				if (cmd_q == CMD_MUL) state_d = S_MUL;
				else if (cmd_q == CMD_DIV || cmd_q == CMD_MOD) state_d = S_DIV;
				else state_d = S_WR;
			end
			S_MUL: state_d = S_WR;
			S_DIV: if (div_done) state_d = S_WR;
			S_WR: if (wr_idx_q == give_q) state_d = S_RESP;
			S_RESP: if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs to ram and divider
	always_comb begin
		ram_req = '0;
		div_start = 1'b0;
		unique case (state_q)
			S_RD_X2: begin
				ram_req.re = 1'b1;
				ram_req.raddr = ADDR_W'(sp_q - SP_W'(2));
			end
			S_RD_X3: begin
				ram_req.re = 1'b1;
				ram_req.raddr = ADDR_W'(sp_q - SP_W'(3));
			end
			S_EXEC: div_start = cmd_q == CMD_DIV || cmd_q == CMD_MOD;
			S_WR: begin
				ram_req.we = wr_idx_q != give_q;
				ram_req.waddr = ADDR_W'(base_q + SP_W'(wr_idx_q));
				ram_req.wdata = w_q[wr_idx_q];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			argc_q <= '0;
			sp_q <= '0;
			top_q <= '0;
			out_valid_q <= 1'b0;
			wr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) argc_q <= cfg_data;
			if (state_q == S_IDLE) wr_idx_q <= '0;
			if (state_q == S_WR) begin
				if (wr_idx_q == give_q) begin
					sp_q <= base_q + SP_W'(give_q);
					top_q <= (give_q == 2'd0) ? drop_top_q : w_q[give_q - 2'd1];
				end else begin
					wr_idx_q <= wr_idx_q + 2'd1;
				end
			end
			if (state_q == S_RESP && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= in_req.cmd;
				lit_q <= cell_t'(in_req.literal);
				give_q <= give;
				base_q <= sp_q - SP_W'(need);
				rd3_q <= need == 2'd3;
				run_q <= !(under || over || divz || nop);
				drop_top_q <= '0;
				priority if (under) status_q <= ST_UNDER;
				else if (over) status_q <= ST_OVER;
				else if (divz) status_q <= ST_DIVZ;
				else status_q <= ST_OK;
			end
			S_RD_X3: x2_q <= rdata;
			S_RD_WAIT: begin
				if (rd3_q) x3_q <= rdata;
				else x2_q <= rdata;
			end
			S_EXEC: begin
				prod_q <= prod_full[CELL_W-1:0];
				drop_top_q <= (base_q != '0) ? x2_q : '0;
				unique case (cmd_q)
					CMD_DUP: begin
						w_q[0] <= top_q;
						w_q[1] <= top_q;
					end
					CMD_SWAP: begin
						w_q[0] <= top_q;
						w_q[1] <= x2_q;
					end
					CMD_OVER: begin
						w_q[0] <= x2_q;
						w_q[1] <= top_q;
						w_q[2] <= x2_q;
					end
					CMD_ROT: begin
						w_q[0] <= x2_q;
						w_q[1] <= top_q;
						w_q[2] <= x3_q;
					end
					default: w_q[0] <= alu;
				endcase
			end
			S_MUL: w_q[0] <= prod_q;
			S_DIV: if (div_done) w_q[0] <= (cmd_q == CMD_DIV) ? div_quo : div_rem;
			S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					out_q.status <= status_q;
					out_q.top_value <= 32'(signed'(top_q));
					out_q.stack_depth <= 7'(sp_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_rsp = out_q;

`ifndef SYNTH
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH)) else $error("stack pointer past depth");
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q == '0 |-> top_q == '0) else $error("empty stack with nonzero top");
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE) else $error("request accepted but idle");
	a_fail_keeps_sp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP && !run_q |-> $stable(sp_q)) else $error("failed word moved sp");
`endif

endmodule
